// ===== sv/gre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_pkg
// Shared constants, codes and controller/datapath interface types for the
// graph reachability engine.
// ----------------------------------------------------------------------------
package gre_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 4096;

    localparam int VIDX_W      = $clog2(MAX_VERTICES);
    localparam int VCNT_W      = 7;
    localparam int ROW_W       = 64;
    localparam int EDGE_CNT_W  = 13;
    localparam int EDGE_IDX_W  = 12;
    localparam int STATUS_W    = 2;

    // stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 80;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(64);

    typedef struct packed {
        logic capture;       // latch the accepted request
        logic load_error;    // result = rejection status
        logic add_read;      // read row of the edge source
        logic add_write;     // set the edge bit, bump the edge count
        logic search_init;   // seed visited/pending with the source
        logic search_step;   // one frontier vertex per cycle while any is pending
        logic query_fin;     // result = visited set
        logic load_out;      // move result into the output register
    } gre_cmd_t;

    typedef struct packed {
        logic is_query;
        logic range_err;
        logic cap_full;
        logic search_done;
        logic out_free;
    } gre_stat_t;

    // index of the single set bit of a one-hot row
    function automatic logic [VIDX_W-1:0] onehot_index(input logic [ROW_W-1:0] oh);
        logic [VIDX_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (oh[i]) begin
                idx = idx | VIDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== sv/gre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_ctrl
// Request sequencer: accepts one item, runs the add or the search in the
// datapath or loads a rejection status, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gre_ctrl
    import gre_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  gre_stat_t stat,
    output gre_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_ADD_WR = 6'b000100,
        ST_SEARCH = 6'b001000,
        ST_DONE   = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (stat.range_err || (!stat.is_query && stat.cap_full)) begin
                    cmd.load_error = 1'b1;
                    state_next     = ST_DONE;
                end else if (stat.is_query) begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end else begin
                    cmd.add_read = 1'b1;
                    state_next   = ST_ADD_WR;
                end
            end
            ST_ADD_WR: begin
                cmd.add_write = 1'b1;
                state_next    = ST_DONE;
            end
            ST_SEARCH: begin
                cmd.search_step = 1'b1;
                if (stat.search_done) begin
                    cmd.query_fin = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the item
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_SPARE: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/gre_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gre_datapath
// Adjacency row memory with per-row valid bits, edge counter, search masks,
// request checks and the output register.
// ----------------------------------------------------------------------------
module gre_datapath
    import gre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [VCNT_W-1:0]     cfg_wdata,
    input  logic                  in_req_type,
    input  logic [VIDX_W-1:0]     in_source_vertex,
    input  logic [VIDX_W-1:0]     in_target_vertex,
    input  gre_cmd_t              cmd,
    output gre_stat_t             stat,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [STATUS_W-1:0]   out_status,
    output logic [EDGE_IDX_W-1:0] out_edge_index,
    output logic [ROW_W-1:0]      out_reachable_mask
);

    logic [ROW_W-1:0]        adj_mem [0:MAX_VERTICES-1];
    logic [MAX_VERTICES-1:0] row_valid_reg;

    logic [VCNT_W-1:0]     vertex_count_reg;
    logic [EDGE_CNT_W-1:0] edges_added_reg;

    logic              req_type_reg;
    logic [VIDX_W-1:0] src_reg;
    logic [VIDX_W-1:0] dst_reg;

    logic [ROW_W-1:0] visited_reg, visited_next;
    logic [ROW_W-1:0] pending_reg, pending_next;

    logic [VIDX_W-1:0] rd_addr;
    logic [ROW_W-1:0]  rd_data_reg;
    logic              rd_row_valid_reg;
    logic              rd_inflight_reg;

    logic [STATUS_W-1:0]   res_status_reg;
    logic [EDGE_IDX_W-1:0] res_index_reg;
    logic [ROW_W-1:0]      res_mask_reg;

    logic                  m_tvalid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [EDGE_IDX_W-1:0] m_index_reg;
    logic [ROW_W-1:0]      m_mask_reg;

    logic [VCNT_W-1:0] n_in_use;
    logic              src_ok, dst_ok;
    logic [ROW_W-1:0]  sel_onehot;
    logic [VIDX_W-1:0] sel_idx;
    logic              issue;
    logic [ROW_W-1:0]  rd_row;

    // clamp the configured count to the matrix size
    assign n_in_use = (vertex_count_reg > VCNT_W'(MAX_VERTICES)) ?
                      VCNT_W'(MAX_VERTICES) : vertex_count_reg;
    assign src_ok   = ({1'b0, src_reg} < n_in_use);
    assign dst_ok   = ({1'b0, dst_reg} < n_in_use);

    // lowest pending vertex
    assign sel_onehot = pending_reg & (~pending_reg + ROW_W'(1));
    assign sel_idx    = onehot_index(sel_onehot);
    assign issue      = cmd.search_step && (pending_reg != '0);

    assign rd_addr = cmd.add_read ? src_reg : sel_idx;
    assign rd_row  = rd_row_valid_reg ? rd_data_reg : '0;

    assign stat.is_query    = (req_type_reg == REQ_QUERY);
    assign stat.range_err   = !src_ok || (!stat.is_query && !dst_ok);
    assign stat.cap_full    = (edges_added_reg >= EDGE_CNT_W'(MAX_EDGES));
    assign stat.search_done = (pending_reg == '0) && !rd_inflight_reg;
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    // row memory: one read, one write port
    always_ff @(posedge aclk) begin
        if (cmd.add_write) begin
            adj_mem[src_reg] <= rd_row | (ROW_W'(1) << dst_reg);
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg      <= adj_mem[rd_addr];
        rd_row_valid_reg <= row_valid_reg[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg    <= '0;
            vertex_count_reg <= VCNT_RESET;
            edges_added_reg  <= '0;
            rd_inflight_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cmd.add_write) begin
                row_valid_reg[src_reg] <= 1'b1;
                edges_added_reg        <= edges_added_reg + EDGE_CNT_W'(1);
            end
            if (cfg_we) begin
                vertex_count_reg <= cfg_wdata;
            end
            rd_inflight_reg <= issue;
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // merge the returning row, retire the issued vertex
    always_comb begin
        visited_next = visited_reg;
        pending_next = pending_reg;
        if (cmd.search_init) begin
            visited_next = ROW_W'(1) << src_reg;
            pending_next = ROW_W'(1) << src_reg;
        end else if (cmd.search_step) begin
            visited_next = visited_reg | (rd_inflight_reg ? rd_row : '0);
            pending_next = (pending_reg & ~sel_onehot) | (rd_inflight_reg ?
                           (rd_row & ~visited_reg) : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            pending_reg <= '0;
        end else begin
            visited_reg <= visited_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_type_reg <= in_req_type;
            src_reg      <= in_source_vertex;
            dst_reg      <= in_target_vertex;
        end
        if (cmd.load_error) begin
            res_status_reg <= stat.range_err ? STATUS_RANGE : STATUS_FULL;
            res_index_reg  <= '0;
            res_mask_reg   <= '0;
        end else if (cmd.add_write) begin
            res_status_reg <= STATUS_OK;
            res_index_reg  <= edges_added_reg[EDGE_IDX_W-1:0];
            res_mask_reg   <= '0;
        end else if (cmd.query_fin) begin
            res_status_reg <= STATUS_OK;
            res_index_reg  <= '0;
            res_mask_reg   <= visited_reg;
        end
        if (cmd.load_out) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_mask_reg   <= res_mask_reg;
        end
    end

    assign m_tvalid           = m_tvalid_reg;
    assign out_status         = m_status_reg;
    assign out_edge_index     = m_index_reg;
    assign out_reachable_mask = m_mask_reg;

endmodule

// ===== sv/graph_reachability_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_engine_unit
// Directed graph store with add-edge and reachable-set query requests.
// ----------------------------------------------------------------------------
// One item at a time. An add checks the request while it reads the source row,
// then writes the row and hands off the result; a rejected request goes from the
// check straight to the hand-off. The result shows on the output in the same
// cycle that the engine can take the next item. A query reads at most one
// adjacency row per cycle from the single registered read port, and when a row
// alone supplies the next vertex the search waits while that row returns; wide
// fan-out overlaps the reads. A new item is accepted while the previous result
// still waits on the output; a stalled output then holds the engine in its
// hand-off step. The adjacency matrix reads as all zeros after reset through
// per-row valid bits; no clearing pass is needed. vertex_count may be written
// only while no request is in flight.
// ----------------------------------------------------------------------------
module graph_reachability_engine_unit
    import gre_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [VCNT_W-1:0]     cfg_wdata,    // vertex_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,      // source_vertex[5:0], target_vertex[11:6]
    input  logic                  s_tuser,      // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // edge_index[11:0], reachable_mask[75:12]
    output logic [STATUS_W-1:0]   m_tuser       // status[1:0]
);

    gre_cmd_t  cmd;
    gre_stat_t stat;

    logic [EDGE_IDX_W-1:0] out_edge_index;
    logic [ROW_W-1:0]      out_reachable_mask;

    gre_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gre_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_req_type        (s_tuser),
        .in_source_vertex   (s_tdata[VIDX_W-1:0]),
        .in_target_vertex   (s_tdata[2*VIDX_W-1:VIDX_W]),
        .cmd                (cmd),
        .stat               (stat),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .out_status         (m_tuser),
        .out_edge_index     (out_edge_index),
        .out_reachable_mask (out_reachable_mask)
    );

    assign m_tdata = {(M_TDATA_W - EDGE_IDX_W - ROW_W)'(0), out_reachable_mask, out_edge_index};

endmodule

// ===== test/graph_reachability_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_engine_unit_test
// Self-checking bench for the graph reachability engine. Edge adds and
// reachable-set queries are streamed in with bursty gaps. Results are drained
// through a receiver with its own stall pattern and compared field by field
// against an in-bench graph model. The bench sweeps the vertex count across
// its extremes and closes with range checks at a small vertex count.
// ----------------------------------------------------------------------------
module graph_reachability_engine_unit_test;
    import gre_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [VIDX_W-1:0] src;
        logic [VIDX_W-1:0] dst;
    } graph_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [EDGE_IDX_W-1:0] edge_idx;
        logic [ROW_W-1:0]      mask;
    } graph_reply_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [VCNT_W-1:0]    cfg_wdata = VCNT_RESET;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = REQ_ADD;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // graph model
    logic [ROW_W-1:0] adj_rows [MAX_VERTICES];
    int unsigned      edges_used;
    logic [VCNT_W-1:0] vcount_cfg;

    graph_req_t   request_backlog[$];
    graph_reply_t reply_expected[$];
    int           error_count = 0;

    // sender pacing
    bit tx_hold    = 1'b0;
    int burst_left = 0;
    int gap_left   = 0;

    // receiver pacing
    int          stall_asks = 0;
    int          stall_seen = 0;
    int          hold_left  = 0;
    logic [31:0] rx_pattern = '1;
    logic [4:0]  rx_step    = '0;

    graph_reachability_engine_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic logic [ROW_W-1:0] reach_from(input logic [VIDX_W-1:0] src);
        logic [ROW_W-1:0] seen;
        logic [ROW_W-1:0] frontier;
        logic [ROW_W-1:0] fresh;
        int v;
        seen = '0;
        seen[src] = 1'b1;
        frontier = seen;
        while (frontier != '0) begin
            v = 0;
            while (!frontier[v]) v++;
            frontier[v] = 1'b0;
            fresh = adj_rows[v] & ~seen;
            seen = seen | fresh;
            frontier = frontier | fresh;
        end
        return seen;
    endfunction

    function automatic int unsigned vertices_live();
        return (vcount_cfg > MAX_VERTICES) ? MAX_VERTICES : vcount_cfg;
    endfunction

    task automatic model_request(input graph_req_t r);
        int unsigned n;
        graph_reply_t rep;
        n = vertices_live();
        rep = '0;
        if (r.kind == REQ_ADD) begin
            if (r.src >= n || r.dst >= n) begin
                rep.status = STATUS_RANGE;
            end else if (edges_used >= MAX_EDGES) begin
                rep.status = STATUS_FULL;
            end else begin
                adj_rows[r.src][r.dst] = 1'b1;
                rep.status = STATUS_OK;
                rep.edge_idx = EDGE_IDX_W'(edges_used);
                edges_used++;
            end
        end else if (r.src >= n) begin
            rep.status = STATUS_RANGE;
        end else begin
            rep.status = STATUS_OK;
            rep.mask = reach_from(r.src);
        end
        reply_expected.insert(reply_expected.size(), rep);
    endtask

    // driver: bursts of items with random gaps, fed from request_backlog
    always @(posedge aclk) begin
        logic fire;
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) begin
                model_request(request_backlog.pop_front());
            end
            // hold an item that was offered but not taken
            offer = s_tvalid && !fire;
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!tx_hold && request_backlog.size() > 0) begin
                    offer = 1'b1;
                    if (burst_left == 0) burst_left = $urandom_range(1, 16);
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= S_TDATA_W'({request_backlog[0].dst, request_backlog[0].src});
                s_tuser <= request_backlog[0].kind;
            end
        end
    end

    // monitor: check each result item, stall on a rotating pattern
    always @(posedge aclk) begin
        graph_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_expected.size() == 0) begin
                    $display("%0t: unexpected item, status %0d index %0d mask %h", $time,
                             m_tuser, m_tdata[EDGE_IDX_W-1:0], m_tdata[EDGE_IDX_W +: ROW_W]);
                    error_count++;
                end else begin
                    want = reply_expected.pop_front();
                    if (m_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[EDGE_IDX_W-1:0] !== want.edge_idx) begin
                        $display("%0t: edge_index expected %0d actual %0d", $time,
                                 want.edge_idx, m_tdata[EDGE_IDX_W-1:0]);
                        error_count++;
                    end
                    if (m_tdata[EDGE_IDX_W +: ROW_W] !== want.mask) begin
                        $display("%0t: reachable_mask expected %h actual %h", $time,
                                 want.mask, m_tdata[EDGE_IDX_W +: ROW_W]);
                        error_count++;
                    end
                end
            end
            if (stall_asks != stall_seen) begin
                stall_seen = stall_asks;
                hold_left = 400;
            end
            if (rx_step == '0) begin
                rx_pattern = ($urandom_range(0, 3) == 0) ? '1 : $urandom;
            end
            rx_step = rx_step + 1'b1;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rx_pattern[rx_step];
            end
        end
    end

    task automatic push_req(input logic kind, input int src, input int dst);
        graph_req_t r;
        r.kind = kind;
        r.src = VIDX_W'(src);
        r.dst = VIDX_W'(dst);
        request_backlog.insert(request_backlog.size(), r);
    endtask

    // let the sender empty its backlog, wait for every outstanding item, then stop it
    task automatic drain();
        do @(negedge aclk);
        while (request_backlog.size() != 0 || s_tvalid || reply_expected.size() != 0);
        tx_hold = 1'b1;
    endtask

    task automatic set_vertex_count(input int value);
        drain();
        repeat (8) @(negedge aclk);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= VCNT_W'(value);
        vcount_cfg = VCNT_W'(value);
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
        tx_hold = 1'b0;
    endtask

    // mostly well-formed traffic: in-range adds, edge chains, queries; some noise
    task automatic push_random(input int count);
        int n;
        int pushed;
        int a;
        int len;
        n = vertices_live();
        pushed = 0;
        while (pushed < count) begin
            case ((n == 0) ? 8 + $urandom_range(0, 1) : $urandom_range(0, 9))
                0, 1, 2, 3: begin
                    push_req(REQ_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
                    pushed++;
                end
                4, 5, 7: begin
                    push_req(REQ_QUERY, $urandom_range(0, n - 1), $urandom_range(0, 63));
                    pushed++;
                end
                6: begin
                    a = $urandom_range(0, n - 1);
                    len = $urandom_range(2, 8);
                    for (int k = 0; k < len; k++) begin
                        push_req(REQ_ADD, (a + k) % n, (a + k + 1) % n);
                    end
                    push_req(REQ_QUERY, a, $urandom_range(0, 63));
                    pushed += len + 1;
                end
                8: begin
                    push_req(REQ_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
                    pushed++;
                end
                default: begin
                    push_req(REQ_QUERY, $urandom_range(0, 63), $urandom_range(0, 63));
                    pushed++;
                end
            endcase
        end
    endtask

    initial begin
        int vc_list [9];
        int cnt_list [9];
        for (int i = 0; i < MAX_VERTICES; i++) adj_rows[i] = '0;
        edges_used = 0;
        vcount_cfg = VCNT_RESET;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        set_vertex_count(64);
        // empty graph: a query sees only its source
        push_req(REQ_QUERY, 0, 0);
        push_req(REQ_QUERY, 63, 63);
        push_req(REQ_ADD, 0, 63);
        push_req(REQ_ADD, 63, 0);
        push_req(REQ_ADD, 63, 63);
        push_req(REQ_ADD, 0, 63);
        push_req(REQ_ADD, 5, 6);
        push_req(REQ_ADD, 6, 7);
        push_req(REQ_ADD, 7, 5);
        push_req(REQ_ADD, 42, 21);
        push_req(REQ_ADD, 21, 42);
        push_req(REQ_QUERY, 0, 63);
        push_req(REQ_QUERY, 5, 0);
        push_req(REQ_QUERY, 42, 0);

        // shrink: range errors, but edges stored earlier still count
        set_vertex_count(4);
        push_req(REQ_ADD, 10, 1);
        push_req(REQ_ADD, 1, 10);
        push_req(REQ_ADD, 10, 20);
        push_req(REQ_QUERY, 10, 0);
        push_req(REQ_QUERY, 0, 0);
        push_req(REQ_ADD, 3, 0);

        set_vertex_count(0);
        push_req(REQ_ADD, 0, 0);
        push_req(REQ_QUERY, 0, 0);

        // beyond the maximum behaves as the maximum
        set_vertex_count(127);
        push_req(REQ_ADD, 63, 1);
        push_req(REQ_QUERY, 62, 0);
        set_vertex_count(65);
        push_req(REQ_QUERY, 63, 0);

        vc_list = '{64, 2, 1, 9, 33, 127, 0, $urandom_range(3, 63), 64};
        cnt_list = '{250, 80, 40, 150, 200, 200, 40, 150, 290};
        for (int p = 0; p < 9; p++) begin
            set_vertex_count(vc_list[p]);
            push_random(cnt_list[p] / 2);
            if (p == 4) begin
                // pushing waits here until the engine has returned everything
                drain();
                tx_hold = 1'b0;
            end
            if (p == 5) stall_asks++;
            push_random(cnt_list[p] - cnt_list[p] / 2);
        end

        // out of range at a small vertex count, in range beside it
        set_vertex_count(10);
        push_req(REQ_ADD, 20, 3);
        push_req(REQ_ADD, 3, 4);
        push_req(REQ_QUERY, 40, 0);
        push_req(REQ_QUERY, 9, 0);

        drain();
        repeat (100) @(posedge aclk);
        if (error_count == 0 && reply_expected.size() == 0) begin
            $display("graph_reachability_engine_unit_test: clean");
        end else begin
            $display("graph_reachability_engine_unit_test: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("graph_reachability_engine_unit_test: errors");
        $finish;
    end

endmodule

// ===== graph_reachability_engine_unit.f =====
sv/gre_pkg.sv
sv/gre_ctrl.sv
sv/gre_datapath.sv
sv/graph_reachability_engine_unit.sv
test/graph_reachability_engine_unit_test.sv
